// ----- hdl/obbsat_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obbsat_pkg
// Shared constants, control word type and microcode program for the
// face-axis box overlap tester.
// ----------------------------------------------------------------------------
package obbsat_pkg;

  localparam int COMPONENT_WIDTH_DEF = 32;

  // vector store: one row per (box, slot), three components per row
  localparam int SLOTS_PER_BOX = 7;
  localparam int STORE_ROWS    = 2 * SLOTS_PER_BOX;
  localparam int ROW_W         = $clog2(STORE_ROWS);

  localparam logic [ROW_W-1:0] ROW_C0    = ROW_W'(0);
  localparam logic [ROW_W-1:0] ROW_C1    = ROW_W'(SLOTS_PER_BOX);
  localparam logic [ROW_W-1:0] ROW_AXIS0 = ROW_W'(1);
  localparam logic [ROW_W-1:0] ROW_AXIS1 = ROW_W'(SLOTS_PER_BOX + 1);
  localparam logic [ROW_W-1:0] ROW_HALF0 = ROW_W'(4);
  localparam logic [ROW_W-1:0] ROW_HALF1 = ROW_W'(SLOTS_PER_BOX + 4);

  localparam logic       OP_LOAD      = 1'b0;
  localparam logic       OP_EVAL      = 1'b1;
  localparam logic [2:0] SLOT_INVALID = 3'd7;
  localparam logic [2:0] NO_AXIS      = 3'd6;

  // prologue (2) + six axes of eight steps + tail for the last check (4)
  localparam int PROG_LEN = 54;
  localparam int PC_W     = $clog2(PROG_LEN);

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_C0,     // latch center of box 0
    ACT_DIFF,   // center difference c1 - c0
    ACT_AXIS,   // latch current axis
    ACT_DOT_D,  // |dot(diff, axis)|, restarts the radius sum
    ACT_DOT_H   // |dot(half, axis)| added to the radius sum
  } act_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    act_t             act;
    logic             chk;      // branch out if the checked axis separates
    logic             last;     // end of program
    logic [2:0]       axis_id;  // axis reported by this check
  } ctl_word_t;

  localparam ctl_word_t CTL_NOP = '{row: '0, act: ACT_NONE, chk: 1'b0,
                                    last: 1'b0, axis_id: '0};

  // Microcode ROM. Step 2+8k starts axis k: axis read, D dot, six half dots.
  // The check of axis k falls three steps into axis k+1, when its sums land.
  function automatic ctl_word_t ucode_rom(input logic [PC_W-1:0] pc);
    ctl_word_t        w;
    logic [PC_W-1:0]  q;
    logic [2:0]       k;
    logic [2:0]       p;
    logic [2:0]       h;
    w = CTL_NOP;
    q = pc - PC_W'(2);
    k = q[PC_W-1:3];
    p = q[2:0];
    h = p - 3'd2;
    if (pc == PC_W'(0)) begin
      w.row = ROW_C0;
      w.act = ACT_C0;
    end else if (pc == PC_W'(1)) begin
      w.row = ROW_C1;
      w.act = ACT_DIFF;
    end else begin
      if (k < 3'd6) begin
        case (p)
          3'd0: begin
            w.act = ACT_AXIS;
            w.row = (k < 3'd3) ? ROW_AXIS0 + ROW_W'(k) : ROW_AXIS1 + ROW_W'(k - 3'd3);
          end
          3'd1: begin
            w.act = ACT_DOT_D;
          end
          default: begin
            w.act = ACT_DOT_H;
            w.row = (h < 3'd3) ? ROW_HALF0 + ROW_W'(h) : ROW_HALF1 + ROW_W'(h - 3'd3);
          end
        endcase
      end
      if (p == 3'd3 && k != 3'd0 && k <= 3'd6) begin
        w.chk     = 1'b1;
        w.axis_id = k - 3'd1;
        w.last    = (k == 3'd6);
      end
    end
    return w;
  endfunction

endpackage

// ----- hdl/obb_face_axis_overlap_test_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obb_face_axis_overlap_test_top
// Face-axis separating-axis overlap test for two oriented boxes.
// ----------------------------------------------------------------------------
// Usage:
//   Input transactions are taken when start is high and busy is low.
//   in_opcode = load writes vec_x/y/z into the (box, slot) row of the vector
//   store; busy stays low and there is no result. Slot 7 is dropped.
//   in_opcode = evaluate raises busy and runs the microcode program: each
//   step issues one store read and one 3-lane dot product, so an axis costs
//   eight steps (axis read, center projection, six half projections).
//   A result transaction is one cycle of out_valid with out_overlap and
//   out_separating_axis. The run ends at the first separating axis k (0-5),
//   or with overlap after the last axis. busy falls in the result cycle, so
//   the next transaction can start then.
//   Rate: one load per cycle while busy is low; none during an evaluate.
//   Reset clears the sequencer and the result strobe; the vector store is
//   not cleared and must be loaded before evaluation.
//   The receiver cannot stall; each result is shown for one cycle only.
// ----------------------------------------------------------------------------
module obb_face_axis_overlap_test_top
  import obbsat_pkg::*;
#(
  parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_opcode,
  input  logic               in_box_sel,
  input  logic [2:0]         in_slot,
  input  logic signed [31:0] in_vec_x,
  input  logic signed [31:0] in_vec_y,
  input  logic signed [31:0] in_vec_z,
  output logic               out_valid,
  output logic               out_overlap,
  output logic [2:0]         out_separating_axis
);

  localparam int CW = COMPONENT_WIDTH;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t          state_r;
  logic [PC_W-1:0] pc_r;
  logic            out_valid_r;
  logic            out_overlap_r;
  logic [2:0]      out_axis_r;

  ctl_word_t        ctl;
  logic             sep;
  logic             accept;
  logic             wr_en;
  logic [ROW_W-1:0] wr_row;
  logic signed [CW-1:0] wx, wy, wz;
  logic [3*CW-1:0]  rd_data;

  assign accept = start && !busy;
  assign busy   = (state_r == ST_RUN);
  assign ctl    = (state_r == ST_RUN) ? ucode_rom(pc_r) : CTL_NOP;

  assign wr_en  = accept && (in_opcode == OP_LOAD) && (in_slot != SLOT_INVALID);
  assign wr_row = in_box_sel ? ROW_C1 + ROW_W'(in_slot) : ROW_W'(in_slot);
  assign wx     = CW'(in_vec_x);
  assign wy     = CW'(in_vec_y);
  assign wz     = CW'(in_vec_z);

  obbsat_ram #(
    .WIDTH (3 * CW),
    .DEPTH (STORE_ROWS)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_row),
    .wdata ({wz, wy, wx}),
    .re    (busy),
    .raddr (ctl.row),
    .rdata (rd_data)
  );

  obbsat_dp #(
    .CW (CW)
  ) u_dp (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .rdata (rd_data),
    .sep   (sep)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      pc_r          <= '0;
      out_valid_r   <= 1'b0;
      out_overlap_r <= 1'b0;
      out_axis_r    <= NO_AXIS;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (accept && in_opcode == OP_EVAL) begin
            state_r <= ST_RUN;
            pc_r    <= '0;
          end
        end
        ST_RUN: begin
          if (ctl.chk && sep) begin
            state_r       <= ST_IDLE;
            out_valid_r   <= 1'b1;
            out_overlap_r <= 1'b0;
            out_axis_r    <= ctl.axis_id;
          end else if (ctl.last) begin
            state_r       <= ST_IDLE;
            out_valid_r   <= 1'b1;
            out_overlap_r <= 1'b1;
            out_axis_r    <= NO_AXIS;
          end else begin
            pc_r <= PC_W'(pc_r + 1'b1);
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_overlap         = out_overlap_r;
  assign out_separating_axis = out_axis_r;

  a_eval_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_opcode == OP_EVAL |=> busy)
    else $error("evaluate accepted but sequencer did not start");

  a_result_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && $past(busy))
    else $error("result strobe outside end of a run");

  a_overlap_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_overlap == (out_separating_axis == NO_AXIS)))
    else $error("overlap flag and axis code disagree");

  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> pc_r < PC_W'(PROG_LEN))
    else $error("microcode step counter ran past program");

endmodule

// ----- hdl/obbsat_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obbsat_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module obbsat_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 14
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/obbsat_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obbsat_dp
// Projection datapath: three multiplier lanes, a 3-term sum with absolute
// value, and the D / radius accumulators with their compare.
// ----------------------------------------------------------------------------
module obbsat_dp
  import obbsat_pkg::*;
#(
  parameter int CW = COMPONENT_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  ctl_word_t       ctl,
  input  logic [3*CW-1:0] rdata,
  output logic            sep
);

  localparam int DWID = CW + 1;     // center difference
  localparam int PW   = 2 * DWID;   // product
  localparam int SW   = PW + 2;     // 3-term dot product
  localparam int AW   = SW + 3;     // sum of six magnitudes

  act_t act1_r, act2_r, act3_r;

  logic signed [CW-1:0]   rcomp  [3];
  logic signed [CW-1:0]   c0_r   [3];
  logic signed [DWID-1:0] diff_r [3];
  logic signed [CW-1:0]   axis_r [3];
  logic signed [DWID-1:0] op_a   [3];
  logic signed [DWID-1:0] op_b   [3];
  logic signed [PW-1:0]   prod_r [3];
  logic signed [SW-1:0]   dot_sum;
  logic [SW-1:0]          mag_r;
  logic [SW-1:0]          d_r;
  logic [AW-1:0]          acc_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rcomp[i] = rdata[i*CW +: CW];
      op_a[i]  = (act1_r == ACT_DOT_D) ? diff_r[i] : DWID'(rcomp[i]);
      op_b[i]  = DWID'(axis_r[i]);
    end
    dot_sum = SW'(prod_r[0]) + SW'(prod_r[1]) + SW'(prod_r[2]);
  end

  // act travels with the data: stage 1 on RAM data, 2 sum, 3 accumulate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act1_r <= ACT_NONE;
      act2_r <= ACT_NONE;
      act3_r <= ACT_NONE;
    end else begin
      act1_r <= ctl.act;
      act2_r <= act1_r;
      act3_r <= act2_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (act1_r == ACT_C0) begin
        c0_r[i] <= rcomp[i];
      end
      if (act1_r == ACT_DIFF) begin
        diff_r[i] <= DWID'(rcomp[i]) - DWID'(c0_r[i]);
      end
      if (act1_r == ACT_AXIS) begin
        axis_r[i] <= rcomp[i];
      end
      prod_r[i] <= op_a[i] * op_b[i];
    end
    mag_r <= dot_sum[SW-1] ? SW'(-dot_sum) : SW'(dot_sum);
    case (act3_r)
      ACT_DOT_D: begin
        d_r   <= mag_r;
        acc_r <= '0;
      end
      ACT_DOT_H: begin
        acc_r <= acc_r + AW'(mag_r);
      end
      default: ;
    endcase
  end

  assign sep = AW'(d_r) > acc_r;

endmodule

// ----- bench/obb_face_axis_overlap_test_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obb_face_axis_overlap_test_top_tb
// Drives vector loads and evaluate commands into the box overlap tester and
// checks every verdict against an exact 128-bit face-axis projection
// predictor. Directed scenes cover degenerate and extreme boxes, then random
// box pairs with random idle gaps and pauses cover the rest.
// ----------------------------------------------------------------------------
module obb_face_axis_overlap_test_top_tb
  import obbsat_pkg::*;
();

  localparam int CW             = COMPONENT_WIDTH_DEF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 64;
  localparam int RANDOM_ITEMS   = 750;

  localparam logic [2:0] SLOT_CENTER = 3'd0;
  localparam logic [2:0] SLOT_AXIS   = 3'd1;
  localparam logic [2:0] SLOT_HALF   = 3'd4;

  // spans of random components, raw Q16.16
  localparam int SPAN_FULL   = 0;
  localparam int SPAN_UNIT   = 32'h0001_0000;
  localparam int SPAN_HALF   = 32'h0002_0000;
  localparam int SPAN_NEAR   = 32'h0004_0000;
  localparam int SPAN_FAR    = 32'h0010_0000;

  localparam logic signed [31:0] COMP_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] COMP_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] ONE_Q16  = 32'sh0001_0000;

  typedef logic signed [CW-1:0] comp_t;
  typedef logic signed [127:0]  acc_t;

  typedef struct packed {
    logic       overlap;
    logic [2:0] axis;
  } verdict_t;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               start      = 1'b0;
  logic               in_opcode  = OP_LOAD;
  logic               in_box_sel = 1'b0;
  logic [2:0]         in_slot    = SLOT_CENTER;
  logic signed [31:0] in_vec_x   = '0;
  logic signed [31:0] in_vec_y   = '0;
  logic signed [31:0] in_vec_z   = '0;
  logic               busy;
  logic               out_valid;
  logic               out_overlap;
  logic [2:0]         out_separating_axis;

  comp_t    box_vecs [2][SLOTS_PER_BOX][3];
  verdict_t pending_verdicts [$];
  int       fault_count  = 0;
  int       loaded_items = 0;
  int       quiet_cycles = 0;
  bit       burst_mode   = 1'b0;

  obb_face_axis_overlap_test_top #(
    .COMPONENT_WIDTH(CW)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_opcode          (in_opcode),
    .in_box_sel         (in_box_sel),
    .in_slot            (in_slot),
    .in_vec_x           (in_vec_x),
    .in_vec_y           (in_vec_y),
    .in_vec_z           (in_vec_z),
    .out_valid          (out_valid),
    .out_overlap        (out_overlap),
    .out_separating_axis(out_separating_axis)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------
  function automatic acc_t widen(comp_t v);
    acc_t r;
    r = v;
    return r;
  endfunction

  function automatic acc_t abs_proj(acc_t vx, acc_t vy, acc_t vz,
                                    acc_t ax, acc_t ay, acc_t az);
    acc_t s;
    s = vx * ax + vy * ay + vz * az;
    return (s < 0) ? -s : s;
  endfunction

  // first face axis whose center distance strictly exceeds the summed radius
  function automatic logic [2:0] face_axis_verdict();
    acc_t dx, dy, dz, ax, ay, az, center_proj, reach;
    dx = widen(box_vecs[1][SLOT_CENTER][0]) - widen(box_vecs[0][SLOT_CENTER][0]);
    dy = widen(box_vecs[1][SLOT_CENTER][1]) - widen(box_vecs[0][SLOT_CENTER][1]);
    dz = widen(box_vecs[1][SLOT_CENTER][2]) - widen(box_vecs[0][SLOT_CENTER][2]);
    for (int b = 0; b < 2; b++) begin
      for (int k = 0; k < 3; k++) begin
        ax = widen(box_vecs[b][SLOT_AXIS + k][0]);
        ay = widen(box_vecs[b][SLOT_AXIS + k][1]);
        az = widen(box_vecs[b][SLOT_AXIS + k][2]);
        center_proj = abs_proj(dx, dy, dz, ax, ay, az);
        reach = '0;
        for (int hb = 0; hb < 2; hb++) begin
          for (int hs = 0; hs < 3; hs++) begin
            reach += abs_proj(widen(box_vecs[hb][SLOT_HALF + hs][0]),
                              widen(box_vecs[hb][SLOT_HALF + hs][1]),
                              widen(box_vecs[hb][SLOT_HALF + hs][2]), ax, ay, az);
          end
        end
        if (center_proj > reach) return 3'(b * 3 + k);
      end
    end
    return NO_AXIS;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (burst_mode || r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic signed [31:0] rand_comp(int span);
    int r;
    r = $urandom_range(99);
    if (span == SPAN_FULL || r < 2) return $urandom;
    if (r < 4) begin
      case ($urandom_range(3))
        0:       return COMP_MAX;
        1:       return COMP_MIN;
        2:       return '0;
        default: return -32'sd1;
      endcase
    end
    return int'($urandom_range(2 * span)) - span;
  endfunction

  // one transaction; start stays high after acceptance so a back-to-back
  // transaction can follow in the same step
  task automatic issue_item(logic op, logic box, logic [2:0] slot,
                            logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] z, int gap);
    verdict_t   v;
    logic [2:0] ax;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    in_opcode  <= op;
    in_box_sel <= box;
    in_slot    <= slot;
    in_vec_x   <= x;
    in_vec_y   <= y;
    in_vec_z   <= z;
    do @(posedge clk); while (busy);
    if (op == OP_EVAL) begin
      ax        = face_axis_verdict();
      v.overlap = (ax == NO_AXIS);
      v.axis    = ax;
      pending_verdicts.push_back(v);
      loaded_items++;
    end else if (slot != SLOT_INVALID) begin
      box_vecs[box][slot][0] = x;
      box_vecs[box][slot][1] = y;
      box_vecs[box][slot][2] = z;
      loaded_items++;
    end
  endtask

  task automatic load_row(logic box, logic [2:0] slot, int span);
    issue_item(OP_LOAD, box, slot, rand_comp(span), rand_comp(span), rand_comp(span),
               pick_gap());
  endtask

  task automatic evaluate_now(int gap);
    issue_item(OP_EVAL, 1'($urandom_range(1)), 3'($urandom_range(7)), $urandom,
               $urandom, $urandom, gap);
  endtask

  task automatic hold_until_quiet();
    start <= 1'b0;
    do @(posedge clk); while (pending_verdicts.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // all-zero boxes: D = R = 0 on every axis, so they overlap
  task automatic test_degenerate_boxes();
    for (int b = 0; b < 2; b++)
      for (int s = 0; s < SLOTS_PER_BOX; s++)
        issue_item(OP_LOAD, b[0], 3'(s), '0, '0, '0, 0);
    evaluate_now(0);
  endtask

  task automatic test_extreme_components();
    issue_item(OP_LOAD, 1'b1, SLOT_CENTER, COMP_MAX, COMP_MAX, COMP_MAX, 0);
    issue_item(OP_LOAD, 1'b0, SLOT_CENTER, COMP_MIN, COMP_MIN, COMP_MIN, 1);
    issue_item(OP_LOAD, 1'b0, SLOT_AXIS, ONE_Q16, '0, '0, 0);
    evaluate_now(0);
    // separation moves to the first axis of box 1
    issue_item(OP_LOAD, 1'b0, SLOT_AXIS, '0, '0, '0, 2);
    issue_item(OP_LOAD, 1'b1, SLOT_AXIS, COMP_MIN, COMP_MAX, COMP_MIN, 0);
    // slot seven load is dropped
    issue_item(OP_LOAD, 1'b1, SLOT_INVALID, COMP_MAX, COMP_MIN, COMP_MAX, 0);
    evaluate_now(3);
    issue_item(OP_LOAD, 1'b0, SLOT_HALF, COMP_MAX, COMP_MIN, COMP_MAX, 0);
    evaluate_now(0);
  endtask

  task automatic test_random_scenes(int n_items);
    int scene;
    int kind;
    int spread;
    scene = 0;
    loaded_items = 0;
    while (loaded_items < n_items) begin
      burst_mode = ($urandom_range(4) == 0);
      kind = $urandom_range(9);
      if (kind == 0) begin
        // noise: dropped slot, full-range rows, stray evaluates
        if ($urandom_range(1))
          issue_item(OP_LOAD, 1'($urandom_range(1)), SLOT_INVALID, $urandom, $urandom,
                     $urandom, pick_gap());
        else
          load_row(1'($urandom_range(1)), 3'($urandom_range(SLOTS_PER_BOX - 1)),
                   SPAN_FULL);
        if ($urandom_range(1)) evaluate_now(pick_gap());
      end else begin
        case ($urandom_range(2))
          0:       spread = SPAN_NEAR;
          1:       spread = SPAN_UNIT;
          default: spread = SPAN_FAR;
        endcase
        for (int b = 0; b < 2; b++) begin
          if ($urandom_range(9) < 7) load_row(b[0], SLOT_CENTER, spread);
          for (int k = 0; k < 3; k++) begin
            if ($urandom_range(9) < 6) load_row(b[0], SLOT_AXIS + 3'(k), SPAN_UNIT);
            if ($urandom_range(9) < 6) load_row(b[0], SLOT_HALF + 3'(k), SPAN_HALF);
          end
        end
        evaluate_now(pick_gap());
      end
      scene++;
      if (scene % 12 == 11) hold_until_quiet();
    end
    burst_mode = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_valid) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result transaction: overlap %0b axis %0d",
                 $time, out_overlap, out_separating_axis);
        fault_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (out_overlap !== want.overlap) begin
          $display("%0t: overlap expected %0b actual %0b",
                   $time, want.overlap, out_overlap);
          fault_count++;
        end
        if (out_separating_axis !== want.axis) begin
          $display("%0t: separating axis expected %0d actual %0d",
                   $time, want.axis, out_separating_axis);
          fault_count++;
        end
      end
    end
  end

  // watchdog: cycles with no transaction on either side
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout waiting for a transaction", $time);
      $display("obb_face_axis_overlap_test_top: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_degenerate_boxes();
    test_extreme_components();
    test_random_scenes(RANDOM_ITEMS);
    hold_until_quiet();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_verdicts.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_verdicts.size());
      fault_count++;
    end
    if (fault_count == 0) begin
      $display("obb_face_axis_overlap_test_top: match");
    end else begin
      $display("obb_face_axis_overlap_test_top: mismatch");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/obbsat_pkg.sv
hdl/obbsat_ram.sv
hdl/obbsat_dp.sv
hdl/obb_face_axis_overlap_test_top.sv
bench/obb_face_axis_overlap_test_top_tb.sv
